### rtl/core/wmf_pkg.sv
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared widths, register codes and structs of the 2-D window minimum filter.
// ----------------------------------------------------------------------------
`default_nettype none

package wmf_pkg;

   localparam int DATA_W        = 32;
   localparam int FRAME_SIZE_W  = 9;
   localparam int WINDOW_SIZE_W = 5;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   // Register index, taken from paddr[2].
   localparam logic REG_FRAME_SIZE  = 1'b0;
   localparam logic REG_WINDOW_SIZE = 1'b1;

   localparam logic [FRAME_SIZE_W-1:0]  FRAME_SIZE_RESET  = 9'd8;
   localparam logic [WINDOW_SIZE_W-1:0] WINDOW_SIZE_RESET = 5'd3;

   typedef struct packed {
      logic [FRAME_SIZE_W-1:0]  frame_size;
      logic [WINDOW_SIZE_W-1:0] window_size;
      logic                     restart;
   } wmf_cfg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] window_minimum;
      logic                     row_last;
      logic                     frame_last;
   } wmf_result_type;

endpackage

`default_nettype wire

### rtl/core/wmf_if.sv
// ----------------------------------------------------------------------------
// wmf_if
// Valid/ready channels of the filter: sample beats in, result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface wmf_req_if import wmf_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface wmf_rsp_if import wmf_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] window_minimum;
   logic                     row_last;
   logic                     frame_last;

   modport source (output valid, output window_minimum, output row_last,
                   output frame_last, input ready);
   modport sink   (input valid, input window_minimum, input row_last,
                   input frame_last, output ready);
endinterface

`default_nettype wire

### rtl/core/wmf_csr.sv
// ----------------------------------------------------------------------------
// wmf_csr
// APB register file holding frame_size and window_size.
// ----------------------------------------------------------------------------
`default_nettype none

module wmf_csr import wmf_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready,
   output      wmf_cfg_type           cfg
);

   logic [FRAME_SIZE_W-1:0]  frame_size_ff, frame_size_in;
   logic [WINDOW_SIZE_W-1:0] window_size_ff, window_size_in;
   logic                     wr_strobe;
   logic                     reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[2];
   assign wr_strobe  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      frame_size_in  = frame_size_ff;
      window_size_in = window_size_ff;
      if (wr_strobe) begin
         case (reg_index)
            REG_FRAME_SIZE:  frame_size_in  = csr_pwdata[FRAME_SIZE_W-1:0];
            REG_WINDOW_SIZE: window_size_in = csr_pwdata[WINDOW_SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_FRAME_SIZE:  csr_prdata = CSR_DATA_W'(frame_size_ff);
         REG_WINDOW_SIZE: csr_prdata = CSR_DATA_W'(window_size_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_size_ff  <= FRAME_SIZE_RESET;
         window_size_ff <= WINDOW_SIZE_RESET;
      end else begin
         frame_size_ff  <= frame_size_in;
         window_size_ff <= window_size_in;
      end
   end

   // Any register write restarts the frame at its first sample.
   assign cfg.frame_size  = frame_size_ff;
   assign cfg.window_size = window_size_ff;
   assign cfg.restart     = wr_strobe;

endmodule

`default_nettype wire

### rtl/core/wmf_engine.sv
// ----------------------------------------------------------------------------
// wmf_engine
// Sequencer around the row sample buffer and the line store of row minima.
// ----------------------------------------------------------------------------
`default_nettype none

module wmf_engine import wmf_pkg::*; #(
   parameter int MAX_SIZE   = 256,
   parameter int MAX_WINDOW = 16
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire wmf_cfg_type    cfg,
   wmf_req_if.sink             req_bus,
   output      logic           push_valid,
   output      wmf_result_type push_data,
   input  wire logic           push_ready
);

   localparam int CW   = $clog2(MAX_SIZE);
   localparam int SW   = $clog2(MAX_WINDOW);
   localparam int FW   = $clog2(MAX_SIZE + 1);
   localparam int WW   = $clog2(MAX_WINDOW + 1);
   localparam int FXW  = (FW > FRAME_SIZE_W) ? FW : FRAME_SIZE_W;
   localparam int WXW  = (WW > WINDOW_SIZE_W) ? WW : WINDOW_SIZE_W;
   localparam int CMPW = (FW > WW) ? FW : WW;
   localparam int HS_DEPTH = MAX_WINDOW * (2 ** CW);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_HRUN = 2'd1;
   localparam logic [1:0] S_VRUN = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   localparam logic [SW-1:0] SLOT_LAST = SW'(MAX_WINDOW - 1);

   // Memories: current row's latest samples and the horizontal minima of the
   // last rows, one row of the line store per slot.
   logic [DATA_W-1:0] row_buf [MAX_WINDOW];
   logic [DATA_W-1:0] line_store [HS_DEPTH];

   logic [1:0]              state_ff, state_in;
   logic [CW-1:0]           col_ff, col_in, row_ff, row_in;
   logic [SW-1:0]           col_slot_ff, col_slot_in, row_slot_ff, row_slot_in;
   logic [CW-1:0]           cur_col_ff, cur_col_in;
   logic [SW-1:0]           cur_row_slot_ff, cur_row_slot_in;
   logic                    row_last_ff, row_last_in, frame_last_ff, frame_last_in;
   logic                    do_v_ff, do_v_in;
   logic [WW-1:0]           k_ff, k_in;
   logic [SW-1:0]           ptr_ff, ptr_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic signed [DATA_W-1:0] acc_ff, acc_in;
   logic signed [DATA_W-1:0] rb_rdata_ff, ls_rdata_ff;

   logic                    rb_we, rb_re, ls_we, ls_re;
   logic [SW+CW-1:0]        ls_addr;
   logic [FXW-1:0]          frame_raw;
   logic [WXW-1:0]          window_raw;
   logic [FW-1:0]           n_eff;
   logic [WW-1:0]           w_eff;
   logic [CMPW-1:0]         n_cmp, w_cmp, c_cmp, r_cmp;
   logic                    accept, last_c, last_r, do_h, do_v, issue;

   // Effective sizes: out-of-range codes clamp to the supported range.
   always_comb begin
      frame_raw  = FXW'(cfg.frame_size);
      window_raw = WXW'(cfg.window_size);
      if (frame_raw == '0 || frame_raw > FXW'(MAX_SIZE))
         n_eff = FW'(MAX_SIZE);
      else
         n_eff = FW'(frame_raw);
      if (window_raw == '0)
         w_eff = WW'(1);
      else if (window_raw > WXW'(MAX_WINDOW))
         w_eff = WW'(MAX_WINDOW);
      else
         w_eff = WW'(window_raw);
   end

   assign n_cmp  = CMPW'(n_eff);
   assign w_cmp  = CMPW'(w_eff);
   assign c_cmp  = CMPW'(col_ff);
   assign r_cmp  = CMPW'(row_ff);
   assign last_c = (c_cmp == n_cmp - CMPW'(1));
   assign last_r = (r_cmp == n_cmp - CMPW'(1));
   assign do_h   = (w_cmp <= n_cmp) && (c_cmp + CMPW'(1) >= w_cmp);
   assign do_v   = do_h && (r_cmp + CMPW'(1) >= w_cmp);

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid & req_bus.ready;
   assign issue         = (k_ff < w_eff);

   always_comb begin
      state_in        = state_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      col_slot_in     = col_slot_ff;
      row_slot_in     = row_slot_ff;
      cur_col_in      = cur_col_ff;
      cur_row_slot_in = cur_row_slot_ff;
      row_last_in     = row_last_ff;
      frame_last_in   = frame_last_ff;
      do_v_in         = do_v_ff;
      k_in            = k_ff;
      ptr_in          = ptr_ff;
      rd_valid_in     = 1'b0;
      acc_in          = acc_ff;
      rb_we           = 1'b0;
      rb_re           = 1'b0;
      ls_we           = 1'b0;
      ls_re           = 1'b0;
      ls_addr         = {cur_row_slot_ff, cur_col_ff};
      push_valid      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rb_we           = 1'b1;
               acc_in          = req_bus.sample;
               k_in            = WW'(1);
               ptr_in          = (col_slot_ff == '0) ? SLOT_LAST : col_slot_ff - SW'(1);
               cur_col_in      = col_ff;
               cur_row_slot_in = row_slot_ff;
               row_last_in     = last_c;
               frame_last_in   = last_c & last_r;
               do_v_in         = do_v;
               state_in        = do_h ? S_HRUN : S_IDLE;
               if (last_c) begin
                  col_in      = '0;
                  col_slot_in = '0;
                  if (last_r) begin
                     row_in      = '0;
                     row_slot_in = '0;
                  end else begin
                     row_in      = row_ff + CW'(1);
                     row_slot_in = (row_slot_ff == SLOT_LAST) ? '0 : row_slot_ff + SW'(1);
                  end
               end else begin
                  col_in      = col_ff + CW'(1);
                  col_slot_in = (col_slot_ff == SLOT_LAST) ? '0 : col_slot_ff + SW'(1);
               end
            end
         end
         S_HRUN: begin
            // One read issued per cycle; the compare follows it in the next cycle.
            if (issue) begin
               rb_re       = 1'b1;
               rd_valid_in = 1'b1;
               k_in        = k_ff + WW'(1);
               ptr_in      = (ptr_ff == '0) ? SLOT_LAST : ptr_ff - SW'(1);
            end
            if (rd_valid_ff && rb_rdata_ff < acc_ff)
               acc_in = rb_rdata_ff;
            if (!issue && !rd_valid_ff) begin
               ls_we    = 1'b1;
               k_in     = WW'(1);
               ptr_in   = (cur_row_slot_ff == '0) ? SLOT_LAST : cur_row_slot_ff - SW'(1);
               state_in = do_v_ff ? S_VRUN : S_IDLE;
            end
         end
         S_VRUN: begin
            ls_addr = {ptr_ff, cur_col_ff};
            if (issue) begin
               ls_re       = 1'b1;
               rd_valid_in = 1'b1;
               k_in        = k_ff + WW'(1);
               ptr_in      = (ptr_ff == '0) ? SLOT_LAST : ptr_ff - SW'(1);
            end
            if (rd_valid_ff && ls_rdata_ff < acc_ff)
               acc_in = ls_rdata_ff;
            if (!issue && !rd_valid_ff)
               state_in = S_OUT;
         end
         S_OUT: begin
            push_valid = 1'b1;
            if (push_ready)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (cfg.restart) begin
         col_in      = '0;
         row_in      = '0;
         col_slot_in = '0;
         row_slot_in = '0;
      end
   end

   assign push_data.window_minimum = acc_ff;
   assign push_data.row_last       = row_last_ff;
   assign push_data.frame_last     = frame_last_ff;

   always_ff @(posedge clock) begin
      if (rb_we)
         row_buf[col_slot_ff] <= req_bus.sample;
      if (rb_re)
         rb_rdata_ff <= row_buf[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (ls_we)
         line_store[ls_addr] <= acc_ff;
      else if (ls_re)
         ls_rdata_ff <= line_store[ls_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         col_ff      <= '0;
         row_ff      <= '0;
         col_slot_ff <= '0;
         row_slot_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         col_slot_ff <= col_slot_in;
         row_slot_ff <= row_slot_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_col_ff      <= cur_col_in;
      cur_row_slot_ff <= cur_row_slot_in;
      row_last_ff     <= row_last_in;
      frame_last_ff   <= frame_last_in;
      do_v_ff         <= do_v_in;
      k_ff            <= k_in;
      ptr_ff          <= ptr_in;
      acc_ff          <= acc_in;
   end

   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      CMPW'(col_ff) < n_cmp && CMPW'(row_ff) < n_cmp)
      else $error("position counter outside the frame");

   a_slots_in_range: assert property (@(posedge clock) disable iff (reset)
      col_slot_ff <= SLOT_LAST && row_slot_ff <= SLOT_LAST)
      else $error("store slot pointer out of range");

   a_read_in_run: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == S_HRUN || state_ff == S_VRUN))
      else $error("read data pending outside a scan");

   a_frame_last_row_last: assert property (@(posedge clock) disable iff (reset)
      push_valid && push_data.frame_last |-> push_data.row_last)
      else $error("frame end without row end");

   a_column_advance: assert property (@(posedge clock) disable iff (reset)
      accept && !cfg.restart |=> (col_ff == $past(col_ff) + CW'(1)) || (col_ff == '0))
      else $error("column counter skipped");

endmodule

`default_nettype wire

### rtl/core/wmf_out_buf.sv
// ----------------------------------------------------------------------------
// wmf_out_buf
// One-entry output register that holds a result beat until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module wmf_out_buf import wmf_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push_valid,
   input  wire wmf_result_type push_data,
   output      logic           push_ready,
   wmf_rsp_if.source           rsp_bus
);

   logic           full_ff, full_in;
   wmf_result_type data_ff;

   assign push_ready = !full_ff || rsp_bus.ready;

   always_comb begin
      full_in = full_ff;
      if (push_valid && push_ready)
         full_in = 1'b1;
      else if (rsp_bus.ready)
         full_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         full_ff <= 1'b0;
      else
         full_ff <= full_in;
   end

   always_ff @(posedge clock) begin
      if (push_valid && push_ready)
         data_ff <= push_data;
   end

   assign rsp_bus.valid          = full_ff;
   assign rsp_bus.window_minimum = data_ff.window_minimum;
   assign rsp_bus.row_last       = data_ff.row_last;
   assign rsp_bus.frame_last     = data_ff.frame_last;

endmodule

`default_nettype wire

### rtl/core/window_min_filter_2d.sv
// ----------------------------------------------------------------------------
// window_min_filter_2d
// Sliding-window minimum over a square frame of signed samples.
// ----------------------------------------------------------------------------
// Samples arrive in raster order, one beat each; a result beat follows the
// sample that completes a full window, carrying the window minimum and flags
// for the last result of a row and of the frame. A sample that completes a
// horizontal window starts a scan of the row buffer, and one that also
// completes a full window then scans the line store before its result is
// offered; the request channel takes no new sample until the result is
// handed on. Each scan walks window_size - 1 entries through the single read
// port of the row buffer or of the line store, with one comparator. The
// stores need no clearing after reset: every entry read has been written
// earlier in the same frame. Any register write restarts the frame at its
// first sample.
`default_nettype none

module window_min_filter_2d import wmf_pkg::*; #(
   parameter int MAX_SIZE   = 256,
   parameter int MAX_WINDOW = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   wmf_req_if.sink                    req_bus,
   wmf_rsp_if.source                  rsp_bus,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   wmf_cfg_type    cfg;
   logic           push_valid;
   logic           push_ready;
   wmf_result_type push_data;

   wmf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   wmf_engine #(
      .MAX_SIZE   (MAX_SIZE),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   wmf_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire

### bench/window_min_filter_2d_test.sv
// ----------------------------------------------------------------------------
// window_min_filter_2d_test
// Self-checking bench for the 2-D sliding-window minimum filter.
// ----------------------------------------------------------------------------
// Sample beats are driven through the request channel while a local model of
// the filter predicts every result beat. A checker compares each accepted
// result beat, field by field, with the oldest prediction. The bench covers
// the reset register values, extreme samples, window and frame sizes at and
// beyond their limits, frame wrap, random frames under several idling
// patterns, and a long receiver hold-off that backs the filter up.
`default_nettype none

module window_min_filter_2d_test;
   import wmf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SIZE   = 256;
   localparam int MAX_WINDOW = 16;
   localparam int SETTLE_CYCLES = 64;
   localparam int DRAIN_LIMIT   = 200000;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   wmf_req_if req_bus ();
   wmf_rsp_if rsp_bus ();

   window_min_filter_2d #(
      .MAX_SIZE   (MAX_SIZE),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Model state of the filter.
   logic [FRAME_SIZE_W-1:0]  frame_reg;
   logic [WINDOW_SIZE_W-1:0] window_reg;
   int                       col_pos;
   int                       row_pos;
   logic signed [DATA_W-1:0] recent_samples [MAX_WINDOW];
   logic signed [DATA_W-1:0] row_min_store [MAX_WINDOW*MAX_SIZE];

   wmf_result_type expected_results [$];
   int             error_count = 0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_goal = 0;
   int hold_done = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch: %s got %h want %h", what, got, want);
      error_count++;
   endtask

   function automatic void predict_window_min(input logic signed [DATA_W-1:0] s);
      int n, w, c, r, k;
      logic signed [DATA_W-1:0] h, v;
      wmf_result_type res;
      n = (frame_reg == 0 || frame_reg > MAX_SIZE) ? MAX_SIZE : int'(frame_reg);
      if (window_reg == 0) w = 1;
      else if (window_reg > MAX_WINDOW) w = MAX_WINDOW;
      else w = int'(window_reg);
      c = col_pos;
      r = row_pos;
      recent_samples[c % MAX_WINDOW] = s;
      if (w <= n && c + 1 >= w) begin
         h = s;
         for (k = 1; k < w; k++) begin
            if (recent_samples[(c - k) % MAX_WINDOW] < h) h = recent_samples[(c - k) % MAX_WINDOW];
         end
         row_min_store[(r % MAX_WINDOW) * MAX_SIZE + c] = h;
         if (r + 1 >= w) begin
            v = h;
            for (k = 1; k < w; k++) begin
               if (row_min_store[((r - k) % MAX_WINDOW) * MAX_SIZE + c] < v) begin
                  v = row_min_store[((r - k) % MAX_WINDOW) * MAX_SIZE + c];
               end
            end
            res.window_minimum = v;
            res.row_last       = (c == n - 1);
            res.frame_last     = (c == n - 1) && (r == n - 1);
            expected_results.push_back(res);
         end
      end
      c++;
      if (c >= n) begin
         c = 0;
         r++;
         if (r >= n) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endfunction

   function automatic logic signed [DATA_W-1:0] random_sample();
      case ($urandom_range(7))
         0: begin
            case ($urandom_range(3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         1, 2, 3: return $signed($urandom_range(16)) - 8;
         default: return $urandom;
      endcase
   endfunction

   // Receiver: random stalls, plus a counted hold-off when one is requested.
   initial begin : result_receiver
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_done < hold_goal) begin
            rsp_bus.ready <= 1'b0;
            hold_done++;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : result_checker
      wmf_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result beat with none expected", rsp_bus.window_minimum, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.window_minimum !== want.window_minimum)
               report_mismatch("window_minimum", rsp_bus.window_minimum, want.window_minimum);
            if (rsp_bus.row_last !== want.row_last)
               report_mismatch("row_last", rsp_bus.row_last, want.row_last);
            if (rsp_bus.frame_last !== want.frame_last)
               report_mismatch("frame_last", rsp_bus.frame_last, want.frame_last);
         end
      end
   end

   // Valid stays high across back-to-back beats; it only drops for a gap.
   task automatic send_sample(input logic signed [DATA_W-1:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= s;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_window_min(s);
   endtask

   task automatic set_idling(input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // A sample that yields no result may still be in flight, so settle too.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_check(input logic reg_index);
      logic [CSR_DATA_W-1:0] want;
      want = (reg_index == REG_FRAME_SIZE) ? CSR_DATA_W'(frame_reg) : CSR_DATA_W'(window_reg);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {reg_index, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== want) report_mismatch("register read", csr_prdata, want);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_index, input int value);
      logic [CSR_DATA_W-1:0] data;
      // Bits above the register width are random and must be ignored.
      if (reg_index == REG_FRAME_SIZE)
         data = ($urandom & ~32'h1FF) | (value & 32'h1FF);
      else
         data = ($urandom & ~32'h1F) | (value & 32'h1F);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (reg_index == REG_FRAME_SIZE) frame_reg = data[FRAME_SIZE_W-1:0];
      else window_reg = data[WINDOW_SIZE_W-1:0];
      col_pos = 0;
      row_pos = 0;
      @(posedge clock);
      csr_check(reg_index);
   endtask

   task automatic configure(input int frame, input int window);
      wait_idle();
      if ($urandom_range(1)) begin
         csr_write(REG_FRAME_SIZE, frame);
         csr_write(REG_WINDOW_SIZE, window);
      end else begin
         csr_write(REG_WINDOW_SIZE, window);
         csr_write(REG_FRAME_SIZE, frame);
      end
   endtask

   task automatic test_reset_defaults();
      set_idling(0, 0);
      csr_check(REG_FRAME_SIZE);
      csr_check(REG_WINDOW_SIZE);
      repeat (64) send_sample(random_sample());
   endtask

   task automatic test_directed_extremes();
      logic signed [DATA_W-1:0] grid [9];
      int i;
      set_idling(0, 0);
      // A 1x1 frame with a 1x1 window passes every sample straight through.
      configure(1, 1);
      send_sample(32'h8000_0000);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h0000_0000);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'h0000_0001);
      grid = '{32'sd7, 32'h8000_0000, 32'sd5, -32'sd1, 32'h7FFF_FFFF,
               32'sd3, 32'sd2, 32'sd0, -32'sd2};
      configure(3, 2);
      for (i = 0; i < 9; i++) send_sample(grid[i]);
      // Window wider than the frame: counters advance, nothing comes out.
      configure(2, 3);
      for (i = 0; i < 4; i++) send_sample(grid[i]);
   endtask

   task automatic test_random_frames(input int send_pct, input int stall_pct, input int frames);
      int n, w, count;
      set_idling(send_pct, stall_pct);
      repeat (frames) begin
         n = $urandom_range(1, 10);
         w = ($urandom_range(5) == 0) ? $urandom_range(1, MAX_WINDOW) : $urandom_range(1, n);
         configure(n, w);
         count = n * n;
         // Sometimes run on into the next frame to exercise the wrap.
         if ($urandom_range(3) == 0) count += $urandom_range(1, 2 * n);
         repeat (count) send_sample(random_sample());
      end
   endtask

   task automatic test_size_limits();
      set_idling(0, 0);
      configure(MAX_SIZE, 2);
      repeat (300) send_sample(random_sample());
      // Zero codes: frame taken as the maximum, window as one.
      set_idling(56, 0);
      configure(0, 0);
      repeat (260) send_sample(random_sample());
      set_idling(0, 56);
      configure(511, 1);
      repeat (100) send_sample(random_sample());
      // Oversized window code is clamped to the widest window.
      set_idling(25, 25);
      configure(17, 31);
      repeat (289) send_sample(random_sample());
   endtask

   task automatic test_backpressure();
      set_idling(0, 0);
      configure(4, 1);
      hold_goal = hold_done + 400;
      repeat (150) send_sample(random_sample());
   endtask

   task automatic finish_run();
      int waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      set_idling(0, 0);
      while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("result beats never arrived", expected_results.size(), 0);
   endtask

   initial begin : test_sequence
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.sample <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      frame_reg  = FRAME_SIZE_RESET;
      window_reg = WINDOW_SIZE_RESET;
      col_pos = 0;
      row_pos = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_directed_extremes();
      test_random_frames(0, 0, 4);
      test_random_frames(56, 0, 4);
      test_random_frames(0, 56, 4);
      test_random_frames(25, 25, 4);
      test_size_limits();
      test_backpressure();
      finish_run();

      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : run_limit
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
rtl/core/wmf_pkg.sv
rtl/core/wmf_if.sv
rtl/core/wmf_csr.sv
rtl/core/wmf_engine.sv
rtl/core/wmf_out_buf.sv
rtl/core/window_min_filter_2d.sv
bench/window_min_filter_2d_test.sv
